/* rtl/atwg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Asymmetric triangle wave generator package
// Shared widths, configuration register indexes and pipeline tag type.
// ----------------------------------------------------------------------------
package atwg_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_W       = 32;
  localparam int OUT_W      = 17;
  localparam int STEP_W     = 32;
  localparam int PEAK_W     = 16;
  localparam int AMPL_W     = 15;
  localparam int DC_W       = 16;

  localparam logic [PEAK_W-1:0] PEAK_RESET = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP    = 3'd0,
    CFG_PHASE_OFFSET  = 3'd1,
    CFG_PEAK_POSITION = 3'd2,
    CFG_AMPLITUDE     = 3'd3,
    CFG_DC_OFFSET     = 3'd4
  } atwg_cfg_idx_t;

  typedef struct packed {
    logic valid;
    logic rise;
  } atwg_tag_t;

endpackage : atwg_pkg
`default_nettype wire

/* rtl/asymmetric_triangle_wave_generator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Asymmetric triangle wave generator
// A request carries a sample index; after the pipeline stages below, out_valid
// pulses for one cycle with the matching sample. One request is taken every
// cycle and busy stays low. The divider resolves one quotient bit per stage
// over AMP_BITS + 1 stages; around it sit three stages for the phase multiply,
// phase add and branch select, and two for the amplitude multiply and offset
// add. The user must write configuration only while no request is in flight;
// the block itself does not enforce it.
// ----------------------------------------------------------------------------
module asymmetric_triangle_wave_generator
  import atwg_pkg::*;
#(
  parameter int PHASE_BITS = 32,
  parameter int AMP_BITS   = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [IN_W-1:0]       in_sample_index,
  output logic                       out_valid,
  output logic signed [OUT_W-1:0]    out_sample_value,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PB = PHASE_BITS;
  localparam int MW = DC_W + AMP_BITS + 1;

  logic [STEP_W-1:0] phase_step_r;
  logic [STEP_W-1:0] phase_offset_r;
  logic [PEAK_W-1:0] peak_r;
  logic [AMPL_W-1:0] amp_r;
  logic [DC_W-1:0]   dc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r   <= '0;
      phase_offset_r <= '0;
      peak_r         <= PEAK_RESET;
      amp_r          <= '0;
      dc_r           <= '0;
    end else if (cfg_we) begin
      case (atwg_cfg_idx_t'(cfg_index))
        CFG_PHASE_STEP:    phase_step_r   <= cfg_wdata[STEP_W-1:0];
        CFG_PHASE_OFFSET:  phase_offset_r <= cfg_wdata[STEP_W-1:0];
        CFG_PEAK_POSITION: peak_r         <= cfg_wdata[PEAK_W-1:0];
        CFG_AMPLITUDE:     amp_r          <= cfg_wdata[AMPL_W-1:0];
        CFG_DC_OFFSET:     dc_r           <= cfg_wdata[DC_W-1:0];
        default: ;
      endcase
    end
  end

  // The peak position is held at one or above so the rising slope never
  // divides by zero.
  logic [PEAK_W-1:0]    peak_eff;
  logic [PB+PEAK_W-1:0] peak_wide;
  logic [PB-1:0]        peak_phase;

  assign peak_eff   = (peak_r == '0) ? PEAK_W'(1) : peak_r;
  assign peak_wide  = {peak_eff, PB'(0)};
  assign peak_phase = peak_wide[PB+PEAK_W-1 -: PB];

  logic              acc;
  logic              v1_r;
  logic [IN_W-1:0]   prod_r;
  logic [2*IN_W-1:0] prod_nxt;

  assign busy     = 1'b0;
  assign acc      = start && !busy;
  assign prod_nxt = in_sample_index * phase_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt[IN_W-1:0];
  end

  logic               v2_r;
  logic [PB-1:0]      p_r;
  logic [STEP_W-1:0]  p32_nxt;
  logic [PB+STEP_W-1:0] p_wide;

  assign p32_nxt = prod_r + phase_offset_r;
  assign p_wide  = {p32_nxt, PB'(0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_wide[PB+STEP_W-1 -: PB];
  end

  atwg_tag_t     tag3_r;
  logic [PB-1:0] num_r;
  logic [PB-1:0] den_r;
  logic          rise_nxt;

  assign rise_nxt = (p_r <= peak_phase);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag3_r.valid <= 1'b0;
    end else begin
      tag3_r.valid <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    tag3_r.rise <= rise_nxt;
    num_r       <= rise_nxt ? p_r : p_r - peak_phase;
    den_r       <= rise_nxt ? peak_phase : PB'(0) - peak_phase;
  end

  atwg_tag_t         div_tag;
  logic [AMP_BITS:0] div_quo;

  atwg_div #(
    .PHASE_BITS (PHASE_BITS),
    .AMP_BITS   (AMP_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (tag3_r),
    .in_num  (num_r),
    .in_den  (den_r),
    .out_tag (div_tag),
    .out_quo (div_quo)
  );

  atwg_tag_t   tagm_r;
  logic [MW-1:0] mul_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tagm_r.valid <= 1'b0;
    end else begin
      tagm_r.valid <= div_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    tagm_r.rise <= div_tag.rise;
    mul_r       <= MW'({amp_r, 1'b0} * div_quo);
  end

  logic [OUT_W:0]    d_ext;
  logic [OUT_W:0]    a_ext;
  logic [OUT_W:0]    dc_ext;
  logic [OUT_W:0]    val_nxt;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_value_r;

  assign d_ext   = {1'b0, mul_r[AMP_BITS +: OUT_W]};
  assign a_ext   = {3'b000, amp_r};
  assign dc_ext  = {{2{dc_r[DC_W-1]}}, dc_r};
  assign val_nxt = (tagm_r.rise ? d_ext - a_ext : a_ext - d_ext) + dc_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= tagm_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= val_nxt[OUT_W-1:0];
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;

endmodule : asymmetric_triangle_wave_generator
`default_nettype wire

/* rtl/atwg_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ramp fraction divider
// Pipelined restoring divider producing floor(num * 2^AMP_BITS / den) for
// num <= den, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module atwg_div
  import atwg_pkg::*;
#(
  parameter int PHASE_BITS = 32,
  parameter int AMP_BITS   = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire atwg_tag_t             in_tag,
  input  wire logic [PHASE_BITS-1:0] in_num,
  input  wire logic [PHASE_BITS-1:0] in_den,
  output atwg_tag_t                  out_tag,
  output logic      [AMP_BITS:0]     out_quo
);

  atwg_tag_t             tag_r [0:AMP_BITS];
  logic [PHASE_BITS-1:0] rem_r [0:AMP_BITS];
  logic [PHASE_BITS-1:0] den_r [0:AMP_BITS];
  logic [AMP_BITS:0]     quo_r [0:AMP_BITS];

  for (genvar k = 0; k <= AMP_BITS; k++) begin : g_stage
    logic [PHASE_BITS:0]   sh_nxt;
    logic [PHASE_BITS-1:0] den_nxt;
    logic [AMP_BITS:0]     quo_prev;
    atwg_tag_t             tag_nxt;
    logic                  ge_nxt;
    logic [PHASE_BITS:0]   diff_nxt;

    if (k == 0) begin : g_first
      assign sh_nxt   = {1'b0, in_num};
      assign den_nxt  = in_den;
      assign quo_prev = '0;
      assign tag_nxt  = in_tag;
    end else begin : g_next
      assign sh_nxt   = {rem_r[k-1], 1'b0};
      assign den_nxt  = den_r[k-1];
      assign quo_prev = quo_r[k-1];
      assign tag_nxt  = tag_r[k-1];
    end

    assign diff_nxt = sh_nxt - {1'b0, den_nxt};
    assign ge_nxt   = (sh_nxt >= {1'b0, den_nxt});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[k].valid <= 1'b0;
      end else begin
        tag_r[k].valid <= tag_nxt.valid;
      end
    end

    always_ff @(posedge clk) begin
      tag_r[k].rise <= tag_nxt.rise;
      rem_r[k]      <= ge_nxt ? diff_nxt[PHASE_BITS-1:0] : sh_nxt[PHASE_BITS-1:0];
      den_r[k]      <= den_nxt;
      quo_r[k]      <= {quo_prev[AMP_BITS-1:0], ge_nxt};
    end
  end

  assign out_tag = tag_r[AMP_BITS];
  assign out_quo = quo_r[AMP_BITS];

endmodule : atwg_div
`default_nettype wire

/* rtl/atwg_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Asymmetric triangle wave generator checker
// Port level checks on request acceptance and result timing.
// ----------------------------------------------------------------------------
module atwg_checker
  import atwg_pkg::*;
#(
  parameter int AMP_BITS = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  localparam int LAT = AMP_BITS + 6;

  // Every accepted request produces its result after the fixed latency.
  a_req_to_result : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted request did not produce a result on time");

  // No result appears without a request the fixed latency earlier.
  a_result_has_req : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching request");

  // Reset flushes every result in flight.
  a_reset_flush : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule : atwg_checker

bind asymmetric_triangle_wave_generator atwg_checker #(
  .AMP_BITS (AMP_BITS)
) u_atwg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
`default_nettype wire
